FILE: src/alrt_pkg.sv
// Package for the ACL/L2CAP reassembly tracker: action codes, table entry
// and result descriptor types, header sizes and queue sizing.
// No dependencies.
`default_nettype none

package alrt_pkg;

    localparam int unsigned HANDLE_BITS_DEF = 12;
    localparam int unsigned CONN_HANDLE_W   = 12;
    localparam int unsigned ACL_HDR_LEN     = 4;
    localparam int unsigned L2CAP_HDR_LEN   = 4;
    localparam int unsigned OUTQ_DEPTH      = 4;
    localparam int unsigned OUTQ_PTR_W      = $clog2(OUTQ_DEPTH);
    localparam int unsigned OUTQ_CNT_W      = $clog2(OUTQ_DEPTH + 1);

    // packet boundary flag, raw_handle bits 13..12
    localparam logic [1:0] PB_CONT  = 2'd1;
    localparam logic [1:0] PB_START = 2'd2;

    typedef enum logic [3:0] {
        ACT_BAD_LEN        = 4'd0,
        ACT_DROP_OLD       = 4'd1,
        ACT_TOO_SMALL      = 4'd2,
        ACT_WHOLE          = 4'd3,
        ACT_START          = 4'd4,
        ACT_UNKNOWN        = 4'd5,
        ACT_APPEND         = 4'd6,
        ACT_APPEND_DELIVER = 4'd7,
        ACT_BAD_FLAG       = 4'd8
    } action_t;

    typedef struct packed {
        logic        valid;
        logic [16:0] total;
        logic [16:0] offset;
    } tbl_entry_t;

    typedef struct packed {
        action_t     action;
        logic [11:0] conn_handle;
        logic [16:0] write_offset;
        logic [15:0] copy_length;
        logic [16:0] total_length;
        logic        last_result;
    } desc_t;

endpackage

`default_nettype wire

FILE: src/alrt_if.sv
// Handshake channels of the reassembly tracker: fragment header in,
// DMA descriptor out. Depends on nothing.
`default_nettype none

interface alrt_hdr_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_handle;
    logic [15:0] acl_len;
    logic [15:0] l2cap_len;
    logic [15:0] rx_length;

    modport source (output valid, raw_handle, acl_len, l2cap_len, rx_length,
                    input ready);
    modport sink (input valid, raw_handle, acl_len, l2cap_len, rx_length,
                  output ready);
endinterface

interface alrt_desc_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [11:0] conn_handle;
    logic [16:0] write_offset;
    logic [15:0] copy_length;
    logic [16:0] total_length;
    logic        last_result;

    modport source (output valid, action, conn_handle, write_offset, copy_length,
                    total_length, last_result, input ready);
    modport sink (input valid, action, conn_handle, write_offset, copy_length,
                  total_length, last_result, output ready);
endinterface

`default_nettype wire

FILE: src/alrt_table.sv
// Per-handle reassembly table: one synchronous RAM, registered read,
// plus the clearing pass after reset. Depends on alrt_pkg.
`default_nettype none

module alrt_table #(
    parameter int unsigned HandleBits = alrt_pkg::HANDLE_BITS_DEF
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       rd_en,
    input  wire [HandleBits-1:0]      rd_addr,
    output alrt_pkg::tbl_entry_t      rd_data,
    input  wire                       wr_en,
    input  wire [HandleBits-1:0]      wr_addr,
    input  alrt_pkg::tbl_entry_t      wr_data,
    output logic                      busy
);
    import alrt_pkg::*;

    localparam int unsigned Depth = 1 << HandleBits;

    tbl_entry_t             mem [Depth];
    tbl_entry_t             rd_data_reg;
    logic                   clr_busy_reg, clr_busy_next;
    logic [HandleBits-1:0]  clr_ptr_reg, clr_ptr_next;
    logic                   mem_we;
    logic [HandleBits-1:0]  mem_waddr;
    tbl_entry_t             mem_wdata;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_ptr_next  = clr_ptr_reg;
        if (clr_busy_reg)
        begin
            clr_ptr_next = clr_ptr_reg + 1'b1;
            if (clr_ptr_reg == HandleBits'(Depth - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_ptr_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_ptr_reg  <= clr_ptr_next;
        end
    end

    // the sweep writes all-zero entries: marked invalid, with zero lengths
    always_comb
    begin
        mem_we    = clr_busy_reg | wr_en;
        mem_waddr = clr_busy_reg ? clr_ptr_reg : wr_addr;
        mem_wdata = clr_busy_reg ? tbl_entry_t'('0) : wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

`default_nettype wire

FILE: src/alrt_outq.sv
// Descriptor queue: registered FIFO between the tracker and the DMA side,
// one push per cycle. Depends on alrt_pkg and alrt_if.
`default_nettype none

module alrt_outq (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           push,
    input  alrt_pkg::desc_t               push_data,
    output logic [alrt_pkg::OUTQ_CNT_W-1:0] count,
    alrt_desc_if.source                   desc
);
    import alrt_pkg::*;

    desc_t                  q_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CNT_W-1:0]  count_reg, count_next;
    logic                   pop;
    desc_t                  head;

    assign pop = desc.valid && desc.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head              = q_mem[rd_ptr_reg];
    assign count             = count_reg;
    assign desc.valid        = (count_reg != '0);
    assign desc.action       = head.action;
    assign desc.conn_handle  = head.conn_handle;
    assign desc.write_offset = head.write_offset;
    assign desc.copy_length  = head.copy_length;
    assign desc.total_length = head.total_length;
    assign desc.last_result  = head.last_result;

endmodule

`default_nettype wire

FILE: src/acl_l2cap_reassembly_tracker.sv
// HCI ACL / L2CAP reassembly tracker, top level.
// Flow: the header and its table entry are registered, ST_EXEC pushes the
// first descriptor into the output queue, and ST_SECOND pushes a second one
// (drop of an old partial). A new header is taken only back in ST_IDLE, with
// room for two descriptors in the queue and the table not clearing.
// Reset: a clearing pass over all 2^HandleBits table entries runs first.
`default_nettype none

module acl_l2cap_reassembly_tracker #(
    parameter int unsigned HandleBits = alrt_pkg::HANDLE_BITS_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    alrt_hdr_if.sink   rx_hdr,
    alrt_desc_if.source desc
);
    import alrt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EXEC   = 3'b010,
        ST_SECOND = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [15:0]            raw_reg, acl_reg, l2_reg, rx_reg;
    desc_t                  second_reg, second_next;
    logic                   accept;
    logic                   tbl_busy;
    tbl_entry_t             rd_entry;
    logic                   wr_en;
    tbl_entry_t             wr_entry;
    logic [OUTQ_CNT_W-1:0]  q_count;
    logic                   push;
    desc_t                  push_data;

    // EXEC decision signals
    logic [HandleBits-1:0]  handle;
    logic [11:0]            conn;
    logic [1:0]             flag;
    logic                   len_bad;
    logic [16:0]            full_len;
    logic [15:0]            pay_len;
    logic [17:0]            proj;
    logic [15:0]            cnt;
    logic                   two_res;
    desc_t                  res_a, res_b;

    assign rx_hdr.ready = (state_reg == ST_IDLE) && !tbl_busy
                          && (q_count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
    assign accept = rx_hdr.valid && rx_hdr.ready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg <= rx_hdr.raw_handle;
            acl_reg <= rx_hdr.acl_len;
            l2_reg  <= rx_hdr.l2cap_len;
            rx_reg  <= rx_hdr.rx_length;
        end
        second_reg <= second_next;
    end

    alrt_table #(
        .HandleBits(HandleBits)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rx_hdr.raw_handle[HandleBits-1:0]),
        .rd_data (rd_entry),
        .wr_en   (wr_en),
        .wr_addr (handle),
        .wr_data (wr_entry),
        .busy    (tbl_busy)
    );

    assign handle   = raw_reg[HandleBits-1:0];
    assign conn     = CONN_HANDLE_W'(handle);
    assign flag     = raw_reg[13:12];
    assign len_bad  = (rx_reg < 16'(ACL_HDR_LEN)) || (acl_reg != rx_reg - 16'(ACL_HDR_LEN));
    assign full_len = {1'b0, l2_reg} + 17'(L2CAP_HDR_LEN + ACL_HDR_LEN);
    assign pay_len  = rx_reg - 16'(ACL_HDR_LEN);

    always_comb
    begin
        res_a    = '{ACT_BAD_LEN, conn, 17'd0, 16'd0, 17'd0, 1'b1};
        res_b    = res_a;
        two_res  = 1'b0;
        wr_en    = 1'b0;
        wr_entry = rd_entry;
        proj     = {1'b0, rd_entry.offset} + 18'(pay_len);
        cnt      = pay_len;
        if (proj > {1'b0, rd_entry.total})
        begin
            cnt  = (rd_entry.total > rd_entry.offset)
                   ? 16'(rd_entry.total - rd_entry.offset) : 16'd0;
            proj = {1'b0, rd_entry.total};
        end

        if (len_bad)
        begin
            res_a.action = ACT_BAD_LEN;
        end
        else if (flag == PB_START)
        begin
            // old partial is dropped first; the new outcome goes second
            res_b = res_a;
            if (acl_reg < 16'(L2CAP_HDR_LEN))
            begin
                res_b.action = ACT_TOO_SMALL;
                wr_entry     = '{1'b0, rd_entry.total, rd_entry.offset};
                wr_en        = rd_entry.valid;
            end
            else if (full_len <= {1'b0, rx_reg})
            begin
                res_b        = '{ACT_WHOLE, conn, 17'd0, rx_reg, {1'b0, rx_reg}, 1'b1};
                wr_entry     = '{1'b0, rd_entry.total, rd_entry.offset};
                wr_en        = rd_entry.valid;
            end
            else
            begin
                res_b        = '{ACT_START, conn, 17'd0, rx_reg, full_len, 1'b1};
                wr_entry     = '{1'b1, full_len, {1'b0, rx_reg}};
                wr_en        = 1'b1;
            end
            if (rd_entry.valid)
            begin
                two_res = 1'b1;
                res_a   = '{ACT_DROP_OLD, conn, rd_entry.offset, 16'd0,
                            rd_entry.total, 1'b0};
            end
            else
            begin
                res_a   = res_b;
            end
        end
        else if (flag == PB_CONT)
        begin
            if (!rd_entry.valid)
            begin
                res_a.action = ACT_UNKNOWN;
            end
            else if (proj == {1'b0, rd_entry.total})
            begin
                res_a    = '{ACT_APPEND_DELIVER, conn, rd_entry.offset, cnt,
                             rd_entry.total, 1'b1};
                wr_entry = '{1'b0, rd_entry.total, rd_entry.offset};
                wr_en    = 1'b1;
            end
            else
            begin
                res_a    = '{ACT_APPEND, conn, rd_entry.offset, cnt, rd_entry.total, 1'b1};
                wr_entry = '{1'b1, rd_entry.total, proj[16:0]};
                wr_en    = 1'b1;
            end
        end
        else
        begin
            res_a.action = ACT_BAD_FLAG;
        end

        if (state_reg != ST_EXEC)
        begin
            wr_en = 1'b0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        push        = 1'b0;
        push_data   = res_a;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                push        = 1'b1;
                second_next = res_b;
                state_next  = two_res ? ST_SECOND : ST_IDLE;
            end
            ST_SECOND:
            begin
                push       = 1'b1;
                push_data  = second_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    alrt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .count     (q_count),
        .desc      (desc)
    );

endmodule

`default_nettype wire

FILE: src/alrt_checker.sv
// Port-level checks for the reassembly tracker, bound to the top level.
// Depends on alrt_pkg.
`default_nettype none

module alrt_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [3:0]  action,
    input wire [16:0] write_offset,
    input wire [15:0] copy_length,
    input wire [16:0] total_length,
    input wire        last_result
);
    import alrt_pkg::*;

    // one header in flight: no accept in the cycle right after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("header accepted while previous one in flight");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(action)
            && $stable(write_offset) && $stable(copy_length) && $stable(total_length)))
        else $error("descriptor changed while stalled");

    // only a drop of an old partial is followed by another item
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_result == (action != ACT_DROP_OLD)))
        else $error("last_result inconsistent with action");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action == ACT_BAD_LEN || action == ACT_TOO_SMALL
            || action == ACT_UNKNOWN || action == ACT_BAD_FLAG))
        |-> (write_offset == '0 && copy_length == '0 && total_length == '0))
        else $error("rejection descriptor carries lengths");

    a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (action <= ACT_BAD_FLAG))
        else $error("undefined action code");

endmodule

bind acl_l2cap_reassembly_tracker alrt_checker u_alrt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (rx_hdr.valid),
    .in_ready     (rx_hdr.ready),
    .out_valid    (desc.valid),
    .out_ready    (desc.ready),
    .action       (desc.action),
    .write_offset (desc.write_offset),
    .copy_length  (desc.copy_length),
    .total_length (desc.total_length),
    .last_result  (desc.last_result)
);

`default_nettype wire

FILE: tb/sv/acl_l2cap_reassembly_tracker_tb.sv
// Testbench for acl_l2cap_reassembly_tracker: drives fragment headers, predicts the
// DMA descriptors from a per-handle partial table and checks every descriptor in order.
// Depends on alrt_pkg, the alrt_hdr_if / alrt_desc_if interfaces and the tracker RTL.
module acl_l2cap_reassembly_tracker_tb;

    import alrt_pkg::*;

    localparam int TABLE_DEPTH = 1 << HANDLE_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;

    alrt_hdr_if  hdr_if ();
    alrt_desc_if desc_if ();

    acl_l2cap_reassembly_tracker i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx_hdr (hdr_if),
        .desc   (desc_if)
    );

    // partial reassembly state as the tracker should hold it
    bit          part_busy  [TABLE_DEPTH];
    logic [16:0] part_total [TABLE_DEPTH];
    logic [16:0] part_fill  [TABLE_DEPTH];

    desc_t       expected_descs [$];
    int          error_count;
    int          cycle_count;
    bit          burst_mode;
    bit          desc_taken;
    int          hold_request;
    logic [11:0] handle_pool [6];

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int idle_draw();
        return burst_mode ? 0 : int'($urandom_range(0, 3));
    endfunction

    function automatic void push_desc(action_t act, logic [11:0] h, logic [16:0] off,
                                      logic [15:0] cnt, logic [16:0] tot, logic last);
        desc_t d;
        d.action       = act;
        d.conn_handle  = h;
        d.write_offset = off;
        d.copy_length  = cnt;
        d.total_length = tot;
        d.last_result  = last;
        expected_descs.push_back(d);
    endfunction

    function automatic void predict_fragment(logic [15:0] raw, logic [15:0] acl,
                                             logic [15:0] l2, logic [15:0] rx);
        logic [11:0] h;
        logic [1:0]  pb;
        int unsigned full_len;
        int unsigned off;
        int unsigned tot;
        int unsigned cnt;
        int unsigned proj;
        h  = raw[11:0];
        pb = raw[13:12];
        if (rx < ACL_HDR_LEN || acl != rx - ACL_HDR_LEN) begin
            push_desc(ACT_BAD_LEN, h, '0, '0, '0, 1'b1);
        end
        else if (pb == PB_START) begin
            if (part_busy[h]) begin
                push_desc(ACT_DROP_OLD, h, part_fill[h], '0, part_total[h], 1'b0);
                part_busy[h] = 1'b0;
            end
            // 17-bit full length, no 16-bit wrap
            full_len = l2 + L2CAP_HDR_LEN + ACL_HDR_LEN;
            if (acl < L2CAP_HDR_LEN)
                push_desc(ACT_TOO_SMALL, h, '0, '0, '0, 1'b1);
            else if (full_len <= rx)
                push_desc(ACT_WHOLE, h, '0, rx, {1'b0, rx}, 1'b1);
            else
            begin
                part_busy[h]  = 1'b1;
                part_total[h] = 17'(full_len);
                part_fill[h]  = {1'b0, rx};
                push_desc(ACT_START, h, '0, rx, 17'(full_len), 1'b1);
            end
        end
        else if (pb == PB_CONT) begin
            if (!part_busy[h]) begin
                push_desc(ACT_UNKNOWN, h, '0, '0, '0, 1'b1);
            end
            else
            begin
                off  = 32'(part_fill[h]);
                tot  = 32'(part_total[h]);
                cnt  = rx - ACL_HDR_LEN;
                proj = off + cnt;
                // truncate to exactly the bytes still missing
                if (proj > tot) begin
                    cnt  = (tot > off) ? tot - off : 0;
                    proj = tot;
                end
                if (proj == tot) begin
                    part_busy[h] = 1'b0;
                    push_desc(ACT_APPEND_DELIVER, h, 17'(off), 16'(cnt), 17'(tot), 1'b1);
                end
                else
                begin
                    part_fill[h] = 17'(proj);
                    push_desc(ACT_APPEND, h, 17'(off), 16'(cnt), 17'(tot), 1'b1);
                end
            end
        end
        else
        begin
            push_desc(ACT_BAD_FLAG, h, '0, '0, '0, 1'b1);
        end
    endfunction

    function automatic logic [15:0] make_raw(logic [1:0] pb, logic [11:0] h);
        return {2'($urandom_range(0, 3)), pb, h};
    endfunction

    task automatic send_fragment(input logic [15:0] raw, input logic [15:0] acl,
                                 input logic [15:0] l2, input logic [15:0] rx);
        int gap;
        gap = idle_draw();
        @(negedge clk);
        if (gap > 0)
        begin
            hdr_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        hdr_if.valid      <= 1'b1;
        hdr_if.raw_handle <= raw;
        hdr_if.acl_len    <= acl;
        hdr_if.l2cap_len  <= l2;
        hdr_if.rx_length  <= rx;
        do @(posedge clk); while (hdr_if.ready !== 1'b1);
        predict_fragment(raw, acl, l2, rx);
    endtask

    task automatic send_start(input logic [11:0] h, input logic [15:0] l2,
                              input logic [15:0] rx);
        send_fragment(make_raw(PB_START, h), rx - 16'd4, l2, rx);
    endtask

    task automatic send_cont(input logic [11:0] h, input logic [15:0] rx);
        send_fragment(make_raw(PB_CONT, h), rx - 16'd4, 16'($urandom), rx);
    endtask

    function automatic void refresh_pool();
        foreach (handle_pool[i])
            handle_pool[i] = 12'($urandom);
        case ($urandom_range(0, 3))
            0: handle_pool[0] = 12'h000;
            1: handle_pool[0] = 12'hFFF;
            default: ;
        endcase
    endfunction

    // one item of a mostly well-formed reassembly stream on handle h
    task automatic reassembly_item(input logic [11:0] h);
        int pick;
        int rx_len;
        int l2_len;
        pick = $urandom_range(0, 99);
        if (part_busy[h] && pick < 75) begin
            rx_len = ($urandom_range(0, 29) == 0) ? $urandom_range(4, 65535)
                                                  : $urandom_range(4, 64);
            send_cont(h, 16'(rx_len));
        end
        else if (pick < 90) begin
            rx_len = ($urandom_range(0, 29) == 0) ? $urandom_range(8, 65535)
                                                  : $urandom_range(4, 90);
            if ($urandom_range(0, 3) == 0 && rx_len >= 8)
                l2_len = $urandom_range(0, rx_len - 8);
            else
            begin
                l2_len = rx_len - 8 + $urandom_range(1, 150);
                if (l2_len < 0)
                    l2_len = 0;
                if (l2_len > 65535)
                    l2_len = 65535;
            end
            send_start(h, 16'(l2_len), 16'(rx_len));
        end
        else if (pick < 95) begin
            // broken length fields
            send_fragment(make_raw(2'($urandom_range(0, 3)), h), 16'($urandom),
                          16'($urandom), 16'($urandom_range(0, 12)));
        end
        else
        begin
            rx_len = $urandom_range(4, 64);
            send_fragment(make_raw(($urandom_range(0, 1) != 0) ? 2'b00 : 2'b11, h),
                          16'(rx_len - 4), 16'($urandom), 16'(rx_len));
        end
    endtask

    task automatic test_header_checks();
        send_fragment(make_raw(PB_START, 12'h000), 16'd0, 16'd0, 16'd0);
        send_fragment(make_raw(PB_CONT, 12'h001), 16'hFFFF, 16'd0, 16'd3);
        send_fragment(make_raw(PB_START, 12'h800), 16'd0, 16'hFFFF, 16'hFFFF);
        send_fragment(make_raw(PB_CONT, 12'hFFF), 16'd1, 16'd0, 16'd4);
        send_fragment(make_raw(2'b00, 12'h7FF), 16'd12, 16'd8, 16'd16);
        send_fragment(make_raw(2'b11, 12'hFFF), 16'd12, 16'd8, 16'd16);
        send_cont(12'h005, 16'd20);
    endtask

    task automatic test_start_cases();
        send_start(12'h010, 16'd0, 16'd4);
        send_start(12'h010, 16'hFFFF, 16'd7);
        send_start(12'h011, 16'd0, 16'd8);
        send_start(12'hFFF, 16'd65527, 16'hFFFF);
        send_start(12'h012, 16'd100, 16'd200);
    endtask

    task automatic test_append_cases();
        send_start(12'h001, 16'd30, 16'd20);
        send_cont(12'h001, 16'd10);
        send_cont(12'h001, 16'd16);
        // oversize continuation gets truncated
        send_start(12'h002, 16'd20, 16'd10);
        send_cont(12'h002, 16'd100);
        // largest full length: 65535 + 8, beyond 16 bits
        send_start(12'hFFF, 16'hFFFF, 16'hFFFF);
        send_cont(12'hFFF, 16'hFFFF);
        send_start(12'h003, 16'd50, 16'd10);
        send_cont(12'h003, 16'd4);
    endtask

    task automatic test_busy_start();
        send_start(12'h003, 16'd50, 16'd10);
        send_start(12'h003, 16'd0, 16'd8);
        send_start(12'h003, 16'd50, 16'd10);
        send_start(12'h003, 16'd0, 16'd4);
        // rejected items must leave the partial alone
        send_start(12'h004, 16'd500, 16'd10);
        send_fragment(make_raw(PB_CONT, 12'h004), 16'd0, 16'd0, 16'd10);
        send_fragment(make_raw(2'b11, 12'h004), 16'd6, 16'd0, 16'd10);
        send_cont(12'h004, 16'd20);
    endtask

    task automatic test_random_reassembly();
        for (int n = 0; n < 1600; n++) begin
            if (n % 200 == 0)
                refresh_pool();
            if (n % 100 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            reassembly_item(handle_pool[$urandom_range(0, 5)]);
        end
        burst_mode = 1'b0;
    endtask

    task automatic test_random_headers();
        logic [15:0] raw;
        logic [15:0] acl;
        logic [15:0] rx;
        for (int n = 0; n < 300; n++) begin
            raw = 16'($urandom);
            if ($urandom_range(0, 1) != 0)
                raw[11:0] = handle_pool[$urandom_range(0, 5)];
            rx = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 8)) : 16'($urandom);
            acl = ($urandom_range(0, 1) != 0) ? rx - 16'd4 : 16'($urandom);
            send_fragment(raw, acl, 16'($urandom), rx);
        end
    endtask

    task automatic test_output_backpressure();
        refresh_pool();
        burst_mode   = 1'b1;
        hold_request = HOLD_CYCLES;
        for (int n = 0; n < 80; n++)
            reassembly_item(handle_pool[$urandom_range(0, 5)]);
        burst_mode = 1'b0;
    endtask

    // descriptor sink: per-item stall draw, plus a long hold on request
    initial
    begin : desc_sink
        int stall_left;
        stall_left    = 0;
        desc_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (desc_taken)
                stall_left = idle_draw();
            desc_taken = 1'b0;
            if (stall_left > 0) begin
                desc_if.ready <= 1'b0;
                stall_left--;
            end
            else
                desc_if.ready <= 1'b1;
        end
    end

    function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : desc_check
        desc_t want;
        if (rst_n && desc_if.valid && desc_if.ready) begin
            desc_taken = 1'b1;
            if (expected_descs.size() == 0) begin
                $display("%0t: descriptor with none expected, expected nothing, actual action %0d",
                         $time, desc_if.action);
                error_count++;
            end
            else
            begin
                want = expected_descs.pop_front();
                check_field("action", want.action, desc_if.action);
                check_field("conn_handle", want.conn_handle, desc_if.conn_handle);
                check_field("write_offset", want.write_offset, desc_if.write_offset);
                check_field("copy_length", want.copy_length, desc_if.copy_length);
                check_field("total_length", want.total_length, desc_if.total_length);
                check_field("last_result", want.last_result, desc_if.last_result);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d descriptors outstanding", $time,
                     expected_descs.size());
            $display("acl_l2cap_reassembly_tracker_tb failed");
            $finish;
        end
    end

    initial
    begin
        error_count       = 0;
        cycle_count       = 0;
        burst_mode        = 1'b0;
        desc_taken        = 1'b0;
        hold_request      = 0;
        rst_n             = 1'b0;
        hdr_if.valid      = 1'b0;
        hdr_if.raw_handle = '0;
        hdr_if.acl_len    = '0;
        hdr_if.l2cap_len  = '0;
        hdr_if.rx_length  = '0;
        foreach (part_busy[i])
            part_busy[i] = 1'b0;
        refresh_pool();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_header_checks();
        test_start_cases();
        test_append_cases();
        test_busy_start();
        test_random_reassembly();
        test_output_backpressure();
        test_random_headers();

        @(negedge clk);
        hdr_if.valid <= 1'b0;
        while (expected_descs.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("acl_l2cap_reassembly_tracker_tb passed");
        else
            $display("acl_l2cap_reassembly_tracker_tb failed");
        $finish;
    end

endmodule

FILE: sim.f
src/alrt_pkg.sv
src/alrt_if.sv
src/alrt_table.sv
src/alrt_outq.sv
src/acl_l2cap_reassembly_tracker.sv
src/alrt_checker.sv
tb/sv/acl_l2cap_reassembly_tracker_tb.sv
